// File: hw/rtl/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg: shared types and constants for the three-plane intersection
// Field layouts, arithmetic widths, codes and divider cell types.
// ----------------------------------------------------------------------------
package tpi_pkg;

  localparam int NORMAL_FRAC_BITS = 14;

  localparam int NRM_W     = 16;
  localparam int DST_W     = 32;
  localparam int EPS_W     = 48;
  localparam int CFG_IDX_W = 1;
  localparam int PNT_W     = 32;

  // exact determinant arithmetic
  localparam int PRD_W = 2 * NRM_W;
  localparam int COF_W = PRD_W + 1;
  localparam int MM_W  = NRM_W + COF_W;
  localparam int MX_W  = DST_W + COF_W;
  localparam int DM_W  = MM_W + 1;
  localparam int DX_W  = MX_W + 1;

  // divider
  localparam int QUO_W     = PNT_W - 1;
  localparam int NUM_W     = DX_W + NORMAL_FRAC_BITS + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int FRONT_LAT = 5;
  localparam int LATENCY   = FRONT_LAT + DIV_STEPS + 1;

  localparam logic [EPS_W-1:0] MAIN_EPS_RST = EPS_W'(4398047);
  localparam logic [EPS_W-1:0] AUX_EPS_RST  = EPS_W'(17592186);

  localparam logic [PNT_W-1:0] SAT_POS = {1'b0, {(PNT_W-1){1'b1}}};
  localparam logic [PNT_W-1:0] SAT_NEG = {1'b1, {(PNT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAIN_EPS = 1'b0,
    CFG_AUX_EPS  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_UNIQUE   = 2'd0,
    KIND_INFINITE = 2'd1,
    KIND_NONE     = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [NRM_W-1:0] plane_a_normal_x;
    logic signed [NRM_W-1:0] plane_a_normal_y;
    logic signed [NRM_W-1:0] plane_a_normal_z;
    logic signed [DST_W-1:0] plane_a_dist;
    logic signed [NRM_W-1:0] plane_b_normal_x;
    logic signed [NRM_W-1:0] plane_b_normal_y;
    logic signed [NRM_W-1:0] plane_b_normal_z;
    logic signed [DST_W-1:0] plane_b_dist;
    logic signed [NRM_W-1:0] plane_c_normal_x;
    logic signed [NRM_W-1:0] plane_c_normal_y;
    logic signed [NRM_W-1:0] plane_c_normal_z;
    logic signed [DST_W-1:0] plane_c_dist;
  } plane_set_t;

  typedef struct packed {
    logic signed [PNT_W-1:0] point_x;
    logic signed [PNT_W-1:0] point_y;
    logic signed [PNT_W-1:0] point_z;
    kind_e                   solution_kind;
  } point_res_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    kind_e                kind;
    div_lane_t [2:0]      lane;
  } div_item_t;

endpackage

// File: hw/rtl/tpi_front.sv
// ----------------------------------------------------------------------------
// tpi_front: determinant front end
// Cross products, dot products and threshold checks; sets up the divider.
// ----------------------------------------------------------------------------
module tpi_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  tpi_pkg::plane_set_t      planes_i,
  input  logic [tpi_pkg::EPS_W-1:0] main_eps_i,
  input  logic [tpi_pkg::EPS_W-1:0] aux_eps_i,
  output logic                     valid_o,
  output tpi_pkg::div_item_t       item_o
);
  import tpi_pkg::*;

  localparam int unsigned NXT1 [3] = '{1, 2, 0};
  localparam int unsigned NXT2 [3] = '{2, 0, 1};

  logic signed [NRM_W-1:0] nx [3];
  logic signed [NRM_W-1:0] ny [3];
  logic signed [NRM_W-1:0] nz [3];
  logic signed [DST_W-1:0] hd [3];
  logic signed [NRM_W-1:0] uv [3][3];
  logic signed [NRM_W-1:0] wv [3][3];

  logic signed [PRD_W-1:0] ppos_q [3][3];
  logic signed [PRD_W-1:0] pneg_q [3][3];
  logic signed [NRM_W-1:0] nx1_q [3];
  logic signed [DST_W-1:0] hd1_q [3];
  logic signed [COF_W-1:0] cof_q [3][3];
  logic signed [NRM_W-1:0] nx2_q [3];
  logic signed [DST_W-1:0] hd2_q [3];
  logic signed [MM_W-1:0]  mm_q [3];
  logic signed [MX_W-1:0]  mx_q [3][3];
  logic signed [DM_W-1:0]  dm_q;
  logic signed [DX_W-1:0]  dx_q [3];
  logic [FRONT_LAT-1:0]    vld_q;
  div_item_t               item_d, item_q;

  always_comb begin
    nx = '{planes_i.plane_a_normal_x, planes_i.plane_b_normal_x, planes_i.plane_c_normal_x};
    ny = '{planes_i.plane_a_normal_y, planes_i.plane_b_normal_y, planes_i.plane_c_normal_y};
    nz = '{planes_i.plane_a_normal_z, planes_i.plane_b_normal_z, planes_i.plane_c_normal_z};
    hd = '{planes_i.plane_a_dist, planes_i.plane_b_dist, planes_i.plane_c_dist};
    // column pairs for the x, y and z cofactor sets
    uv[0] = ny; wv[0] = nz;
    uv[1] = nz; wv[1] = nx;
    uv[2] = nx; wv[2] = ny;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ppos_q[k][i] <= PRD_W'(uv[k][NXT1[i]]) * PRD_W'(wv[k][NXT2[i]]);
        pneg_q[k][i] <= PRD_W'(uv[k][NXT2[i]]) * PRD_W'(wv[k][NXT1[i]]);
        cof_q[k][i]  <= COF_W'(ppos_q[k][i]) - COF_W'(pneg_q[k][i]);
        mx_q[k][i]   <= MX_W'(hd2_q[i]) * MX_W'(cof_q[k][i]);
      end
      mm_q[k] <= MM_W'(nx2_q[k]) * MM_W'(cof_q[0][k]);
      dx_q[k] <= DX_W'(mx_q[k][0]) + DX_W'(mx_q[k][1]) + DX_W'(mx_q[k][2]);
    end
    nx1_q <= nx;
    hd1_q <= hd;
    nx2_q <= nx1_q;
    hd2_q <= hd1_q;
    dm_q  <= DM_W'(mm_q[0]) + DM_W'(mm_q[1]) + DM_W'(mm_q[2]);
    item_q <= item_d;
  end

  always_comb begin
    logic [DM_W-1:0]  mag_m;
    logic [DX_W-1:0]  mag_x;
    logic [NUM_W-1:0] den;
    logic [NUM_W-1:0] num;
    logic             uniq;
    mag_m = dm_q[DM_W-1] ? DM_W'(-dm_q) : DM_W'(dm_q);
    uniq  = mag_m > DM_W'(main_eps_i);
    den   = NUM_W'(mag_m) << 1;
    item_d = '0;
    for (int k = 0; k < 3; k++) begin
      mag_x = dx_q[k][DX_W-1] ? DX_W'(-dx_q[k]) : DX_W'(dx_q[k]);
      // round to nearest: (2*|n|*2^f + d) / (2*d)
      num = (NUM_W'(mag_x) << (NORMAL_FRAC_BITS + 1)) + NUM_W'(mag_m);
      item_d.lane[k].rem = num;
      item_d.lane[k].dsh = den << (QUO_W - 1);
      item_d.lane[k].quo = '0;
      item_d.lane[k].neg = dx_q[k][DX_W-1] ^ dm_q[DM_W-1];
      item_d.lane[k].ovf = num >= (den << QUO_W);
      if (k == 0) begin
        if (uniq) begin
          item_d.kind = KIND_UNIQUE;
        end else if (mag_x > DX_W'(aux_eps_i)) begin
          item_d.kind = KIND_NONE;
        end else begin
          item_d.kind = KIND_INFINITE;
        end
      end
    end
  end

  assign valid_o = vld_q[FRONT_LAT-1];
  assign item_o  = item_q;

endmodule

// File: hw/rtl/tpi_cell.sv
// ----------------------------------------------------------------------------
// tpi_cell: one divider cell
// Resolves one quotient bit on each of the three lanes per cycle.
// ----------------------------------------------------------------------------
module tpi_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tpi_pkg::div_item_t item_i,
  output logic               valid_o,
  output tpi_pkg::div_item_t item_o
);
  import tpi_pkg::*;

  logic      valid_q;
  div_item_t item_d, item_q;

  always_comb begin
    logic ge;
    item_d = item_i;
    for (int l = 0; l < 3; l++) begin
      ge = item_i.lane[l].rem >= item_i.lane[l].dsh;
      if (ge) begin
        item_d.lane[l].rem = item_i.lane[l].rem - item_i.lane[l].dsh;
      end
      item_d.lane[l].quo = {item_i.lane[l].quo[QUO_W-2:0], ge};
      item_d.lane[l].dsh = item_i.lane[l].dsh >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/three_plane_intersection_top.sv
// ----------------------------------------------------------------------------
// three_plane_intersection_top: common point of three planes
// Cramer's rule with exact determinants and a chain of divider cells.
//
//   channel   direction  handshake                 payload
//   command   in         start / busy              plane_i      (plane_set_t)
//   result    out        result_valid_o strobe     result_o     (point_res_t)
//   config    in         cfg_we_i / cfg_idx_i      cfg_wdata_i  (48 bits)
//
// one item per cycle; results come out in the order of their starts
// pipeline: five front-end stages, one cell per quotient bit (31), one output register
// busy is never raised; results cannot be held off
// reset clears valid bits and restores both thresholds
// ----------------------------------------------------------------------------
module three_plane_intersection_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tpi_pkg::plane_set_t           plane_i,
  output logic                          result_valid_o,
  output tpi_pkg::point_res_t           result_o,
  input  logic                          cfg_we_i,
  input  logic [tpi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tpi_pkg::EPS_W-1:0]     cfg_wdata_i
);
  import tpi_pkg::*;

  logic [EPS_W-1:0] main_eps_q, aux_eps_q;
  logic             stg_vld [DIV_STEPS+1];
  div_item_t        stg_item [DIV_STEPS+1];
  logic             res_vld_q;
  point_res_t       res_d, res_q;
  logic [PNT_W-1:0] pnt [3];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_eps_q <= MAIN_EPS_RST;
      aux_eps_q  <= AUX_EPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAIN_EPS: main_eps_q <= cfg_wdata_i;
        CFG_AUX_EPS:  aux_eps_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tpi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .planes_i   (plane_i),
    .main_eps_i (main_eps_q),
    .aux_eps_i  (aux_eps_q),
    .valid_o    (stg_vld[0]),
    .item_o     (stg_item[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
    tpi_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[s]),
      .item_i  (stg_item[s]),
      .valid_o (stg_vld[s+1]),
      .item_o  (stg_item[s+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (stg_item[DIV_STEPS].lane[l].ovf) begin
        pnt[l] = stg_item[DIV_STEPS].lane[l].neg ? SAT_NEG : SAT_POS;
      end else if (stg_item[DIV_STEPS].lane[l].neg) begin
        pnt[l] = -{1'b0, stg_item[DIV_STEPS].lane[l].quo};
      end else begin
        pnt[l] = {1'b0, stg_item[DIV_STEPS].lane[l].quo};
      end
      if (stg_item[DIV_STEPS].kind != KIND_UNIQUE) begin
        pnt[l] = '0;
      end
    end
    res_d.point_x       = pnt[0];
    res_d.point_y       = pnt[1];
    res_d.point_z       = pnt[2];
    res_d.solution_kind = stg_item[DIV_STEPS].kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= stg_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // every accepted start is followed by a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY result_valid_o)
    else $error("result strobe missing after accepted start");

  // no point is reported unless the solution is unique
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.solution_kind != KIND_UNIQUE |->
      result_o.point_x == '0 && result_o.point_y == '0 && result_o.point_z == '0)
    else $error("nonzero point with non-unique solution");

  // front end and divider chain advance in lockstep
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld[0] |-> ##DIV_STEPS stg_vld[DIV_STEPS])
    else $error("item lost in divider chain");

endmodule
